// ===== hw/rtl/rac_pkg.sv =====
package rac_pkg;

  localparam int POS_W = 32;
  localparam int DIR_W = 16;
  localparam int CFG_W = 29;
  localparam int C_W = 33;
  localparam int W_W = 33;
  localparam int PROD_W = 49;
  localparam int DOT_W = 51;
  localparam int SQ_W = 66;
  localparam int S2_W = 39;
  localparam int NUM_W = 84;
  localparam int MAG_W = 83;
  localparam int DIV_W = 43;
  localparam int Q_W = 32;
  localparam int LO_W = 26;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 29'd268435;
  localparam logic signed [S2_W-1:0] ONE_Q28 = 39'sd268435456;
  localparam logic [Q_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic signed [POS_W-1:0] axis_origin_x;
    logic signed [POS_W-1:0] axis_origin_y;
    logic signed [POS_W-1:0] axis_origin_z;
    logic signed [DIR_W-1:0] axis_dir_x;
    logic signed [DIR_W-1:0] axis_dir_y;
    logic signed [DIR_W-1:0] axis_dir_z;
    logic signed [POS_W-1:0] ray_origin_x;
    logic signed [POS_W-1:0] ray_origin_y;
    logic signed [POS_W-1:0] ray_origin_z;
    logic signed [DIR_W-1:0] ray_dir_x;
    logic signed [DIR_W-1:0] ray_dir_y;
    logic signed [DIR_W-1:0] ray_dir_z;
  } query_t;

  typedef struct packed {
    logic signed [Q_W-1:0] axis_param;
    logic                  valid_res;
    logic                  saturated;
  } result_t;

  typedef struct packed {
    logic                    ok;
    logic signed [C_W-1:0]   c;
    logic signed [DOT_W-1:0] wv;
    logic signed [DOT_W-1:0] wu;
    logic [CFG_W-1:0]        s2;
  } job_t;

  typedef struct packed {
    logic             ok;
    logic             neg;
    logic             sat;
    logic [MAG_W-1:0] rem;
    logic [DIV_W-1:0] d;
    logic [Q_W-1:0]   q;
  } div_stage_t;

endpackage

// ===== hw/rtl/rac_stream_if.sv =====
interface rac_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rac_front.sv =====
module rac_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rac_pkg::CFG_W-1:0]   min_sin_squared,
  rac_stream_if.sink                  query,
  output rac_pkg::job_t               job,
  output logic                        job_valid,
  input  logic                        job_ready
);

  logic v1, v2, v3, en;
  logic signed [rac_pkg::W_W-1:0]    w1 [3];
  logic signed [rac_pkg::DIR_W-1:0]  u1 [3];
  logic signed [rac_pkg::DIR_W-1:0]  r1 [3];
  logic signed [rac_pkg::C_W-1:0]    c1, c2;
  logic signed [rac_pkg::PROD_W-1:0] wvp [3];
  logic signed [rac_pkg::PROD_W-1:0] wup [3];
  logic signed [rac_pkg::SQ_W-1:0]   cc;
  logic signed [rac_pkg::S2_W-1:0]   s2f;
  logic signed [rac_pkg::DOT_W-1:0]  wv_sum, wu_sum;
  rac_pkg::query_t q;

  assign q = query.data;
  assign en = !v3 || job_ready;
  assign query.ready = en;
  assign job_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= query.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // difference of origins and the direction cosine
  always_ff @(posedge clk) begin
    if (en) begin
      w1[0] <= rac_pkg::W_W'(q.axis_origin_x) - rac_pkg::W_W'(q.ray_origin_x);
      w1[1] <= rac_pkg::W_W'(q.axis_origin_y) - rac_pkg::W_W'(q.ray_origin_y);
      w1[2] <= rac_pkg::W_W'(q.axis_origin_z) - rac_pkg::W_W'(q.ray_origin_z);
      u1[0] <= q.axis_dir_x;
      u1[1] <= q.axis_dir_y;
      u1[2] <= q.axis_dir_z;
      r1[0] <= q.ray_dir_x;
      r1[1] <= q.ray_dir_y;
      r1[2] <= q.ray_dir_z;
      c1 <= rac_pkg::C_W'(q.axis_dir_x * q.ray_dir_x)
          + rac_pkg::C_W'(q.axis_dir_y * q.ray_dir_y)
          + rac_pkg::C_W'(q.axis_dir_z * q.ray_dir_z);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        wvp[i] <= rac_pkg::PROD_W'(w1[i] * r1[i]);
        wup[i] <= rac_pkg::PROD_W'(w1[i] * u1[i]);
      end
      cc <= rac_pkg::SQ_W'(c1 * c1);
      c2 <= c1;
    end
  end

  assign wv_sum = rac_pkg::DOT_W'(wvp[0]) + rac_pkg::DOT_W'(wvp[1])
                + rac_pkg::DOT_W'(wvp[2]);
  assign wu_sum = rac_pkg::DOT_W'(wup[0]) + rac_pkg::DOT_W'(wup[1])
                + rac_pkg::DOT_W'(wup[2]);
  assign s2f = rac_pkg::ONE_Q28 - rac_pkg::S2_W'(cc >>> 28);

  // reject near-parallel and degenerate directions here
  always_ff @(posedge clk) begin
    if (en) begin
      job.ok <= !s2f[rac_pkg::S2_W-1] && (s2f != '0)
             && (s2f >= $signed({{(rac_pkg::S2_W-rac_pkg::CFG_W){1'b0}}, min_sin_squared}));
      job.c  <= c2;
      job.wv <= wv_sum;
      job.wu <= wu_sum;
      job.s2 <= s2f[rac_pkg::CFG_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/rac_queue.sv =====
module rac_queue #(
  parameter int DEPTH = rac_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  rac_pkg::job_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output rac_pkg::job_t pop_data,
  output logic          pop_valid,
  input  logic          pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rac_pkg::job_t   mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            do_push, do_pop;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// ===== hw/rtl/rac_back.sv =====
module rac_back (
  input  logic          clk,
  input  logic          rst,
  input  rac_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_pop,
  rac_stream_if.source  result
);

  localparam int QW = rac_pkg::Q_W;
  localparam int NV = QW + 4;

  logic en;
  logic [NV-1:0] vld;

  logic signed [59:0] p_lo;
  logic signed [57:0] p_hi;
  logic signed [rac_pkg::DOT_W-1:0] wu_b1;
  logic [rac_pkg::CFG_W-1:0] s2_b1, s2_b2;
  logic ok_b1, ok_b2, ok_b3, neg_b3;
  logic signed [rac_pkg::NUM_W-1:0] num;
  logic [rac_pkg::MAG_W-1:0] mag_b3;
  logic [rac_pkg::DIV_W-1:0] d_b3;
  logic [rac_pkg::MAG_W-1:0] sat_bound;
  rac_pkg::div_stage_t stg [QW+1];
  rac_pkg::div_stage_t fin;
  logic [QW-1:0] res;

  assign en = !result.valid || result.ready;
  assign job_pop = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], job_valid};
    end
  end

  // split c*(w.v) into two narrow products
  always_ff @(posedge clk) begin
    if (en) begin
      p_lo  <= 60'(job.c * $signed({1'b0, job.wv[rac_pkg::LO_W-1:0]}));
      p_hi  <= 58'(job.c * $signed(job.wv[rac_pkg::DOT_W-1:rac_pkg::LO_W]));
      wu_b1 <= job.wu;
      s2_b1 <= job.s2;
      ok_b1 <= job.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= (rac_pkg::NUM_W'(p_hi) <<< rac_pkg::LO_W) + rac_pkg::NUM_W'(p_lo)
           - (rac_pkg::NUM_W'(wu_b1) <<< 28);
      s2_b2 <= s2_b1;
      ok_b2 <= ok_b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_b3 <= num[rac_pkg::NUM_W-1];
      mag_b3 <= num[rac_pkg::NUM_W-1] ? rac_pkg::MAG_W'(-num) : rac_pkg::MAG_W'(num);
      d_b3   <= {s2_b2, 14'd0};
      ok_b3  <= ok_b2;
    end
  end

  // quotient exceeds the 32-bit range when |num| reaches (limit+1)*d
  assign sat_bound = (rac_pkg::MAG_W'(d_b3) << (QW-1))
                   + (neg_b3 ? rac_pkg::MAG_W'(d_b3) : '0);

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].ok  <= ok_b3;
      stg[0].neg <= neg_b3;
      stg[0].sat <= mag_b3 >= sat_bound;
      stg[0].rem <= mag_b3;
      stg[0].d   <= d_b3;
      stg[0].q   <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [rac_pkg::MAG_W-1:0] dsh;
    logic ge;
    assign dsh = rac_pkg::MAG_W'(stg[k].d) << (QW-1-k);
    assign ge  = stg[k].rem >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        stg[k+1].ok  <= stg[k].ok;
        stg[k+1].neg <= stg[k].neg;
        stg[k+1].sat <= stg[k].sat;
        stg[k+1].d   <= stg[k].d;
        stg[k+1].rem <= ge ? stg[k].rem - dsh : stg[k].rem;
        stg[k+1].q   <= {stg[k].q[QW-2:0], ge};
      end
    end
  end

  assign fin = stg[QW];
  assign res = fin.sat ? (fin.neg ? rac_pkg::NEG_LIMIT : rac_pkg::POS_LIMIT)
                       : (fin.neg ? QW'(-fin.q) : fin.q);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= vld[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.data.axis_param <= fin.ok ? $signed(res) : '0;
      result.data.valid_res  <= fin.ok;
      result.data.saturated  <= fin.ok && fin.sat;
    end
  end

endmodule

// ===== hw/rtl/ray_axis_closest_parameter.sv =====
// Closest-approach parameter of an axis line to a ray, one request per clock.
// Throughput is one request a cycle when results are taken as they appear;
// a request passes through classification, the queue, and then product,
// restoring division (one quotient bit per stage) and output register. The
// front end stalls only when the queue is full, the back end only when the
// output register holds an untaken result. The user, not the block, must
// ensure that min_sin_squared is written only while the block is idle.
module ray_axis_closest_parameter #(
  parameter int QUEUE_DEPTH = rac_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [rac_pkg::CFG_W-1:0] cfg_wr_data,
  rac_stream_if.sink                query,
  rac_stream_if.source              result
);

  logic [rac_pkg::CFG_W-1:0] min_sin_squared;
  rac_pkg::job_t push_data, pop_data;
  logic push_valid, push_ready, pop_valid, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sin_squared <= rac_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      min_sin_squared <= cfg_wr_data;
    end
  end

  rac_front u_front (
    .clk             (clk),
    .rst             (rst),
    .min_sin_squared (min_sin_squared),
    .query           (query),
    .job             (push_data),
    .job_valid       (push_valid),
    .job_ready       (push_ready)
  );

  rac_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop        (pop)
  );

  rac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (pop_data),
    .job_valid (pop_valid),
    .job_pop   (pop),
    .result    (result)
  );

endmodule

// ===== bench/rac_result_checker.sv =====
`timescale 1ns / 100ps

module rac_result_checker
  import rac_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  rac_stream_if            query,
  rac_stream_if            result,
  output int               fail_count,
  output int               outstanding
);

  logic [CFG_W-1:0] sin_sq_floor;
  result_t          expected_params[$];

  function automatic result_t closest_param(input query_t q, input logic [CFG_W-1:0] floor_v);
    longint            au[3], av[3], wd[3];
    longint            c, wv, wu, cm, s2;
    logic [127:0]      sq, mag, dv, quo, limit;
    logic signed [127:0] num;
    logic              neg;
    result_t           r;
    au = '{longint'(q.axis_dir_x), longint'(q.axis_dir_y), longint'(q.axis_dir_z)};
    av = '{longint'(q.ray_dir_x), longint'(q.ray_dir_y), longint'(q.ray_dir_z)};
    wd[0] = longint'(q.axis_origin_x) - longint'(q.ray_origin_x);
    wd[1] = longint'(q.axis_origin_y) - longint'(q.ray_origin_y);
    wd[2] = longint'(q.axis_origin_z) - longint'(q.ray_origin_z);
    c = 0;
    wv = 0;
    wu = 0;
    for (int i = 0; i < 3; i++) begin
      c += au[i] * av[i];
      wv += wd[i] * av[i];
      wu += wd[i] * au[i];
    end
    cm = (c < 0) ? -c : c;
    sq = 128'(cm) * 128'(cm);
    s2 = longint'(1 << 28) - longint'(sq >> 28);
    r = '0;
    // near parallel, or a degenerate direction pair
    if (s2 <= 0 || s2 < longint'(floor_v)) return r;
    num = (128'(signed'(c)) * 128'(signed'(wv))) - (128'(signed'(wu)) <<< 28);
    neg = num[127];
    mag = neg ? -num : num;
    dv = 128'(s2) << 14;
    quo = mag / dv;
    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    r.valid_res = 1'b1;
    r.saturated = (quo > limit);
    if (quo > limit) quo = limit;
    r.axis_param = neg ? -quo[31:0] : quo[31:0];
    return r;
  endfunction

  assign outstanding = expected_params.size();

  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst) begin
      sin_sq_floor <= CFG_RESET;
      expected_params.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) sin_sq_floor <= cfg_wr_data;
      if (query.valid && query.ready)
        expected_params.push_back(closest_param(query.data, sin_sq_floor));
      if (result.valid && result.ready) begin
        got = result.data;
        if (expected_params.size() == 0) begin
          $error("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_params.pop_front();
          if (got.axis_param !== exp_r.axis_param)
            $error("axis_param expected %0d got %0d", exp_r.axis_param, got.axis_param);
          if (got.valid_res !== exp_r.valid_res)
            $error("valid_res expected %0b got %0b", exp_r.valid_res, got.valid_res);
          if (got.saturated !== exp_r.saturated)
            $error("saturated expected %0b got %0b", exp_r.saturated, got.saturated);
          if (got !== exp_r) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

// ===== bench/tb_ray_axis_closest_parameter.sv =====
`timescale 1ns / 100ps

module tb_ray_axis_closest_parameter;
  import rac_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 190;

  typedef logic signed [DIR_W-1:0] dir3_t [3];

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  int               send_idle_pct = 25;
  int               take_stall_pct = 65;
  int               fail_count;
  int               outstanding;
  int               cycles = 0;

  rac_stream_if #(.T(query_t))  query_ch ();
  rac_stream_if #(.T(result_t)) result_ch ();

  ray_axis_closest_parameter DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .query       (query_ch),
    .result      (result_ch)
  );

  rac_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .query       (query_ch),
    .result      (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    query_ch.valid = 1'b0;
    query_ch.data = '0;
    result_ch.ready = 1'b0;
  end

  always @(negedge clk)
    result_ch.ready <= ($urandom_range(99) >= take_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_axis_closest_parameter test failed");
      $finish;
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_query(input query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(negedge clk);
    end
    query_ch.valid <= 1'b1;
    query_ch.data <= q;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_floor(input logic [CFG_W-1:0] value);
    query_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (45) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic dir3_t unit_dir(input real bx, input real by, input real bz, input real jit);
    real   x, y, z, n;
    dir3_t d;
    x = bx + jit * ($urandom_range(2000) - 1000.0) / 1000.0;
    y = by + jit * ($urandom_range(2000) - 1000.0) / 1000.0;
    z = bz + jit * ($urandom_range(2000) - 1000.0) / 1000.0;
    n = $sqrt(x * x + y * y + z * z);
    if (n < 1.0e-6) begin
      x = 1.0;
      n = 1.0;
    end
    d[0] = DIR_W'($rtoi(x / n * 16384.0));
    d[1] = DIR_W'($rtoi(y / n * 16384.0));
    d[2] = DIR_W'($rtoi(z / n * 16384.0));
    return d;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos(input bit wide);
    int sh;
    sh = wide ? 0 : $urandom_range(20, 4);
    return signed'($urandom) >>> sh;
  endfunction

  function automatic logic signed [DIR_W-1:0] rand_comp();
    return DIR_W'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic query_t build(input dir3_t u, input dir3_t v, input bit wide);
    query_t q;
    q.axis_origin_x = rand_pos(wide);
    q.axis_origin_y = rand_pos(wide);
    q.axis_origin_z = rand_pos(wide);
    q.ray_origin_x = rand_pos(wide);
    q.ray_origin_y = rand_pos(wide);
    q.ray_origin_z = rand_pos(wide);
    {q.axis_dir_x, q.axis_dir_y, q.axis_dir_z} = {u[0], u[1], u[2]};
    {q.ray_dir_x, q.ray_dir_y, q.ray_dir_z} = {v[0], v[1], v[2]};
    return q;
  endfunction

  function automatic query_t random_query();
    dir3_t u, v;
    int    kind;
    kind = $urandom_range(99);
    u = unit_dir($urandom_range(2000) - 1000.0, $urandom_range(2000) - 1000.0,
                 $urandom_range(2000) - 1000.0, 0.0);
    if (kind < 60) begin
      v = unit_dir($urandom_range(2000) - 1000.0, $urandom_range(2000) - 1000.0,
                   $urandom_range(2000) - 1000.0, 0.0);
      return build(u, v, 1'b0);
    end else if (kind < 78) begin
      // ray almost along the axis, either way round
      v = unit_dir(u[0], u[1], u[2], real'($urandom_range(800)));
      if (kind[0]) v = '{-v[0], -v[1], -v[2]};
      return build(u, v, 1'b0);
    end else if (kind < 90) begin
      v = unit_dir($urandom_range(2000) - 1000.0, $urandom_range(2000) - 1000.0,
                   $urandom_range(2000) - 1000.0, 0.0);
      return build(u, v, 1'b1);
    end
    u = '{rand_comp(), rand_comp(), rand_comp()};
    v = '{rand_comp(), rand_comp(), rand_comp()};
    return build(u, v, $urandom_range(1));
  endfunction

  task automatic run_directed();
    dir3_t  ex, ey, ez, nx, diag, zero;
    query_t q;
    ex = '{16'sd16384, 16'sd0, 16'sd0};
    ey = '{16'sd0, 16'sd16384, 16'sd0};
    ez = '{16'sd0, 16'sd0, 16'sd16384};
    nx = '{-16'sd16384, 16'sd0, 16'sd0};
    diag = '{16'sd16384, 16'sd16384, 16'sd16384};
    zero = '{16'sd0, 16'sd0, 16'sd0};
    send_query('0);
    send_query(build(ex, ey, 1'b0));
    send_query(build(ex, ez, 1'b1));
    send_query(build(ex, ex, 1'b0));
    send_query(build(ex, nx, 1'b0));
    send_query(build(diag, diag, 1'b0));
    send_query(build(diag, '{-16'sd16384, -16'sd16384, -16'sd16384}, 1'b0));
    send_query(build(zero, ey, 1'b1));
    send_query(build(ey, zero, 1'b0));
    // large separation along the axis: clip low, then high
    q = build(ex, ey, 1'b0);
    q.axis_origin_x = 32'sh7FFF_FFFF;
    q.ray_origin_x = 32'sh8000_0000;
    send_query(q);
    q.axis_origin_x = 32'sh8000_0000;
    q.ray_origin_x = 32'sh7FFF_FFFF;
    send_query(q);
    q = build(nx, ez, 1'b0);
    q.axis_origin_x = 32'sh8000_0000;
    q.ray_origin_x = 32'sh7FFF_FFFF;
    send_query(q);
    q = build(unit_dir(1.0, 0.0, 0.0, 0.0), unit_dir(1.0, 0.03, 0.0, 0.0), 1'b1);
    send_query(q);
    q = '1;
    send_query(q);
  endtask

  initial begin
    logic [CFG_W-1:0] floors[6];
    floors = '{29'd0, 29'd268435456, 29'd268435, 29'($urandom_range(268435456)),
               29'd67108864, 29'd1048576};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    for (int p = 0; p < 6; p++) begin
      write_floor(floors[p]);
      if (p == 2) begin
        send_idle_pct = 65;
        take_stall_pct = 25;
      end else if (p == 4) begin
        send_idle_pct = 0;
        take_stall_pct = 0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) send_query(random_query());
    end
    query_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0)
      $display("ray_axis_closest_parameter test passed");
    else
      $display("ray_axis_closest_parameter test failed");
    $finish;
  end

endmodule
